[design/tcphc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the end-around-carry adder of the TCP checksum block.
// Used by tcphc_front, tcphc_back, tcp_pseudo_header_checksum and tcphc_checker; depends on nothing.
package tcphc_pkg;

  localparam int WordBits = 16;
  localparam int LengthBitsDefault = 16;
  localparam int ChecksumWordIndexDefault = 8;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 64;
  localparam logic [WordBits-1:0] ProtoTcp = 16'd6;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgIpVersionSix = 3'd0,
    CfgSrcHigh      = 3'd1,
    CfgSrcLow       = 3'd2,
    CfgDstHigh      = 3'd3,
    CfgDstLow       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                   v6;
    logic [CfgDataBits-1:0] src_hi;
    logic [CfgDataBits-1:0] src_lo;
    logic [CfgDataBits-1:0] dst_hi;
    logic [CfgDataBits-1:0] dst_lo;
  } cfg_t;

  function automatic logic [WordBits-1:0] oc_add(input logic [WordBits-1:0] a,
                                                 input logic [WordBits-1:0] b);
    logic [WordBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordBits-1:0] + WordBits'(s[WordBits]);
  endfunction

endpackage

[design/tcphc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for segment bytes and checksum results.
// Depends on nothing.
interface tcphc_seg_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_byte;
  logic       last_byte;

  modport source (output valid, output segment_byte, output last_byte, input ready);
  modport sink (input valid, input segment_byte, input last_byte, output ready);
endinterface

interface tcphc_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] ones_sum;
  logic [15:0] checksum_value;
  logic [15:0] segment_length;
  logic        length_overflow;

  modport source (output valid, output ones_sum, output checksum_value,
                  output segment_length, output length_overflow, input ready);
  modport sink (input valid, input ones_sum, input checksum_value,
                input segment_length, input length_overflow, output ready);
endinterface

[design/tcphc_front.sv]
`timescale 1ns / 1ps
// Front end: takes segment bytes, pairs them into words and keeps the running sum.
// Depends on tcphc_pkg and tcphc_seg_if.
module tcphc_front #(
  parameter int LENGTH_BITS = tcphc_pkg::LengthBitsDefault,
  parameter int CHECKSUM_WORD_INDEX = tcphc_pkg::ChecksumWordIndexDefault
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  tcphc_seg_if.sink                                seg,
  input  logic                                     q_full_i,
  output logic                                     push_o,
  output logic [tcphc_pkg::WordBits+LENGTH_BITS:0] push_data_o
);

  logic [15:0]            sum_q, sum_d, sum_new;
  logic [LENGTH_BITS-1:0] count_q, count_d, count_new;
  logic [7:0]             held_q, held_d;
  logic                   odd_q, odd_d;
  logic                   ovf_q, ovf_d, ovf_new;
  logic                   accept, sat, skip, add_en;
  logic [15:0]            word;

  assign seg.ready = ~q_full_i;
  assign accept = seg.valid & seg.ready;

  assign sat = (count_q == {LENGTH_BITS{1'b1}});
  assign skip = ~sat && (count_q[LENGTH_BITS-1:1] ==
                         (LENGTH_BITS-1)'(CHECKSUM_WORD_INDEX));
  assign word = odd_q ? {held_q, seg.segment_byte} : {seg.segment_byte, 8'h00};
  assign add_en = (odd_q | seg.last_byte) & ~skip;
  assign sum_new = add_en ? tcphc_pkg::oc_add(sum_q, word) : sum_q;
  assign count_new = sat ? count_q : count_q + LENGTH_BITS'(1);
  assign ovf_new = ovf_q | sat;

  assign push_o = accept & seg.last_byte;
  assign push_data_o = {sum_new, count_new, ovf_new};

  always_comb begin
    sum_d = sum_q;
    count_d = count_q;
    held_d = held_q;
    odd_d = odd_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (seg.last_byte) begin
        sum_d = '0;
        count_d = '0;
        held_d = '0;
        odd_d = 1'b0;
        ovf_d = 1'b0;
      end else begin
        sum_d = sum_new;
        count_d = count_new;
        ovf_d = ovf_new;
        odd_d = ~odd_q;
        held_d = odd_q ? held_q : seg.segment_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      count_q <= '0;
      held_q <= '0;
      odd_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      count_q <= count_d;
      held_q <= held_d;
      odd_q <= odd_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

[design/tcphc_fifo.sv]
`timescale 1ns / 1ps
// Two-entry queue that carries finished segment sums from the front to the back end.
// Depends on nothing.
module tcphc_fifo #(
  parameter int DATA_BITS = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_BITS-1:0] push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output logic [DATA_BITS-1:0] pop_data_o
);

  logic [DATA_BITS-1:0] mem_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q;
  logic                 do_push, do_pop;

  assign full_o = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop = pop_i & valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[design/tcphc_back.sv]
`timescale 1ns / 1ps
// Back end: adds the pseudo-header to a segment sum in a pipelined adder tree.
// Depends on tcphc_pkg and tcphc_res_if.
module tcphc_back #(
  parameter int LENGTH_BITS = tcphc_pkg::LengthBitsDefault
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  tcphc_pkg::cfg_t                          cfg_i,
  input  logic                                     q_valid_i,
  input  logic [tcphc_pkg::WordBits+LENGTH_BITS:0] q_data_i,
  output logic                                     q_pop_o,
  tcphc_res_if.source                              res
);

  typedef struct packed {
    logic [15:0] len;
    logic        ovf;
  } side_t;

  localparam int Stages = 6;

  logic [15:0]            sum_in;
  logic [LENGTH_BITS-1:0] len_in;
  logic [31:0]            len_wide;
  logic                   ovf_in;

  logic [15:0] w0 [20];
  logic [15:0] l1_d [10];
  logic [15:0] l2_d [5];
  logic [15:0] l3_d [3];
  logic [15:0] l4_d [2];
  logic [15:0] l5_d;

  logic [15:0] lvl0_q [20];
  logic [15:0] lvl1_q [10];
  logic [15:0] lvl2_q [5];
  logic [15:0] lvl3_q [3];
  logic [15:0] lvl4_q [2];
  logic [15:0] lvl5_q;

  side_t             side_q [Stages];
  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] rdy;

  assign sum_in = q_data_i[tcphc_pkg::WordBits+LENGTH_BITS -: 16];
  assign len_in = q_data_i[LENGTH_BITS:1];
  assign ovf_in = q_data_i[0];
  assign len_wide = 32'(len_in);

  always_comb begin
    for (int i = 0; i < 20; i++) begin
      w0[i] = '0;
    end
    w0[0] = sum_in;
    w0[18] = len_wide[15:0];
    w0[19] = tcphc_pkg::ProtoTcp;
    if (cfg_i.v6) begin
      for (int k = 0; k < 4; k++) begin
        w0[1+k] = cfg_i.src_hi[63-16*k -: 16];
        w0[5+k] = cfg_i.src_lo[63-16*k -: 16];
        w0[9+k] = cfg_i.dst_hi[63-16*k -: 16];
        w0[13+k] = cfg_i.dst_lo[63-16*k -: 16];
      end
      w0[17] = len_wide[31:16];
    end else begin
      w0[1] = cfg_i.src_lo[31:16];
      w0[2] = cfg_i.src_lo[15:0];
      w0[3] = cfg_i.dst_lo[31:16];
      w0[4] = cfg_i.dst_lo[15:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      l1_d[i] = tcphc_pkg::oc_add(lvl0_q[2*i], lvl0_q[2*i+1]);
    end
    for (int i = 0; i < 5; i++) begin
      l2_d[i] = tcphc_pkg::oc_add(lvl1_q[2*i], lvl1_q[2*i+1]);
    end
    l3_d[0] = tcphc_pkg::oc_add(lvl2_q[0], lvl2_q[1]);
    l3_d[1] = tcphc_pkg::oc_add(lvl2_q[2], lvl2_q[3]);
    l3_d[2] = lvl2_q[4];
    l4_d[0] = tcphc_pkg::oc_add(lvl3_q[0], lvl3_q[1]);
    l4_d[1] = lvl3_q[2];
    l5_d = tcphc_pkg::oc_add(lvl4_q[0], lvl4_q[1]);
  end

  always_comb begin
    rdy[Stages-1] = ~valid_q[Stages-1] | res.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
  end

  assign q_pop_o = rdy[0] & q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= q_valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      lvl0_q <= w0;
      side_q[0] <= '{len: len_in[15:0], ovf: ovf_in};
    end
    if (rdy[1] && valid_q[0]) begin
      lvl1_q <= l1_d;
      side_q[1] <= side_q[0];
    end
    if (rdy[2] && valid_q[1]) begin
      lvl2_q <= l2_d;
      side_q[2] <= side_q[1];
    end
    if (rdy[3] && valid_q[2]) begin
      lvl3_q <= l3_d;
      side_q[3] <= side_q[2];
    end
    if (rdy[4] && valid_q[3]) begin
      lvl4_q <= l4_d;
      side_q[4] <= side_q[3];
    end
    if (rdy[5] && valid_q[4]) begin
      lvl5_q <= l5_d;
      side_q[5] <= side_q[4];
    end
  end

  assign res.valid = valid_q[Stages-1];
  assign res.ones_sum = lvl5_q;
  assign res.checksum_value = ~lvl5_q;
  assign res.segment_length = side_q[Stages-1].len;
  assign res.length_overflow = side_q[Stages-1].ovf;

endmodule

[design/tcp_pseudo_header_checksum.sv]
`timescale 1ns / 1ps
// TCP checksum with IPv4/IPv6 pseudo-header: ties together configuration, front end,
// queue and back end. Depends on tcphc_pkg, tcphc_if, tcphc_front, tcphc_fifo, tcphc_back.
//
// The block takes one segment byte per clock cycle while the queue has room, with
// no gaps between segments; that rate is set by the single end-around-carry add in
// the front end. The pseudo-header is folded in by a five-level adder tree, and a
// result is held until taken while new bytes keep flowing into a two-entry queue.
// Input stalls only when that queue is full. Configuration reads live, so write it
// only while no segment is in progress and every result has been taken.
module tcp_pseudo_header_checksum #(
  parameter int LENGTH_BITS = tcphc_pkg::LengthBitsDefault,
  parameter int CHECKSUM_WORD_INDEX = tcphc_pkg::ChecksumWordIndexDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tcphc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [tcphc_pkg::CfgDataBits-1:0] cfg_wdata_i,
  tcphc_seg_if.sink                         seg_i,
  tcphc_res_if.source                       res_o
);

  localparam int EntryBits = tcphc_pkg::WordBits + LENGTH_BITS + 1;

  tcphc_pkg::cfg_t      cfg_q;
  logic                 push, q_full, q_pop, q_valid;
  logic [EntryBits-1:0] push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcphc_pkg::CfgIpVersionSix: cfg_q.v6 <= cfg_wdata_i[0];
        tcphc_pkg::CfgSrcHigh:      cfg_q.src_hi <= cfg_wdata_i;
        tcphc_pkg::CfgSrcLow:       cfg_q.src_lo <= cfg_wdata_i;
        tcphc_pkg::CfgDstHigh:      cfg_q.dst_hi <= cfg_wdata_i;
        tcphc_pkg::CfgDstLow:       cfg_q.dst_lo <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  tcphc_front #(
    .LENGTH_BITS(LENGTH_BITS),
    .CHECKSUM_WORD_INDEX(CHECKSUM_WORD_INDEX)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .seg(seg_i),
    .q_full_i(q_full),
    .push_o(push),
    .push_data_o(push_data)
  );

  tcphc_fifo #(
    .DATA_BITS(EntryBits)
  ) u_fifo (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .push_data_i(push_data),
    .full_o(q_full),
    .pop_i(q_pop),
    .valid_o(q_valid),
    .pop_data_o(q_data)
  );

  tcphc_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_q),
    .q_valid_i(q_valid),
    .q_data_i(q_data),
    .q_pop_o(q_pop),
    .res(res_o)
  );

endmodule

[design/tcphc_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the TCP checksum block and the bind that attaches them.
// Depends on tcphc_pkg and tcp_pseudo_header_checksum.
module tcphc_checker #(
  parameter int LENGTH_BITS = tcphc_pkg::LengthBitsDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [15:0] ones_sum_i,
  input logic [15:0] checksum_value_i,
  input logic [15:0] segment_length_i,
  input logic        length_overflow_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(ones_sum_i) &&
      $stable(segment_length_i) && $stable(length_overflow_i))
    else $error("Result changed while stalled.");

  a_complement: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> checksum_value_i == ~ones_sum_i)
    else $error("Checksum is not the complement of the sum.");

  a_sum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> ones_sum_i != 16'h0000)
    else $error("Sum is zero although the protocol word is always added.");

  a_sat_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && length_overflow_i && (LENGTH_BITS == 16) |->
      segment_length_i == 16'hFFFF)
    else $error("Overflow flagged without a saturated length.");

endmodule

bind tcp_pseudo_header_checksum tcphc_checker #(
  .LENGTH_BITS(LENGTH_BITS)
) u_tcphc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .ones_sum_i(res_o.ones_sum),
  .checksum_value_i(res_o.checksum_value),
  .segment_length_i(res_o.segment_length),
  .length_overflow_i(res_o.length_overflow)
);
